[hw/rtl/dsr_pkg.sv]
// Shared types and constants for the dual sonar echo ranger.
package dsr_pkg;

   localparam int unsigned TimeWidth    = 16;
   localparam int unsigned TicksWidth   = 8;
   localparam int unsigned ScaleWidth   = 10;
   localparam int unsigned MmWidth      = 16;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned CsrIdxWidth  = 2;

   // Echo time times scale: 16 + 10 bits.
   localparam int unsigned ProdWidth = TimeWidth + ScaleWidth;

   // Exact floor(p / 1000) for p below 2**26: (p * RecipMult) >> RecipShift.
   localparam int unsigned RecipShift = 36;
   localparam int unsigned RecipWidth = 27;
   localparam logic [RecipWidth-1:0] RecipMult = 27'd68719477;
   localparam int unsigned QuotWidth = 17;
   localparam int unsigned RecipProdWidth = ProdWidth + RecipWidth;

   localparam logic [TimeWidth-1:0]  ModuloReset = 16'd65534;
   localparam logic [TicksWidth-1:0] TicksReset  = 8'd10;
   localparam logic [ScaleWidth-1:0] ScaleReset  = 10'd170;
   localparam logic [MmWidth-1:0]    MmMax       = 16'hFFFF;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_COUNTER_MODULO = 2'd0,
      REG_TRIGGER_TICKS  = 2'd1,
      REG_DISTANCE_SCALE = 2'd2,
      REG_UNUSED         = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [TimeWidth-1:0]  counter_modulo;
      logic [TicksWidth-1:0] trigger_ticks;
      logic [ScaleWidth-1:0] distance_scale;
   } cfg_type;

   // One tick's outcome, passed from the timing logic to the scaling pipeline.
   typedef struct packed {
      logic                 trigger_left;
      logic                 trigger_right;
      logic [TimeWidth-1:0] left_time;
      logic [TimeWidth-1:0] right_time;
   } tick_word_type;

endpackage

[hw/rtl/dsr_channels.sv]
// Request and response channel interfaces for the dual sonar echo ranger.
interface dsr_req_if;
   logic valid;
   logic ready;
   logic echo_left;
   logic echo_right;
   logic start_trigger;

   modport source (output valid, output echo_left, output echo_right,
                   output start_trigger, input ready);
   modport sink   (input valid, input echo_left, input echo_right,
                   input start_trigger, output ready);
endinterface

interface dsr_rsp_if
   import dsr_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               trigger_left;
   logic               trigger_right;
   logic [MmWidth-1:0] left_mm;
   logic [MmWidth-1:0] right_mm;

   modport source (output valid, output trigger_left, output trigger_right,
                   output left_mm, output right_mm, input ready);
   modport sink   (input valid, input trigger_left, input trigger_right,
                   input left_mm, input right_mm, output ready);
endinterface

[hw/rtl/dsr_tick.sv]
// Per-tick echo edge timing and trigger pulse sequencing, with its output register.
module dsr_tick
   import dsr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic          echo_left,
   input  logic          echo_right,
   input  logic          start_trigger,
   output logic          out_valid,
   input  logic          out_ready,
   output tick_word_type out_word
);

   logic                  last_left_ff, last_left_in;
   logic                  last_right_ff, last_right_in;
   logic [TimeWidth-1:0]  count_ff, count_in;
   logic [TimeWidth-1:0]  left_time_ff, left_time_in;
   logic [TimeWidth-1:0]  right_time_ff, right_time_in;
   logic                  right_next_ff, right_next_in;
   logic [TicksWidth-1:0] pulse_ff, pulse_in;
   logic                  side_right_ff, side_right_in;
   logic                  valid_ff;
   tick_word_type         word_ff, word_in;
   logic                  accept;
   logic                  cleared;
   logic [TicksWidth-1:0] pulse_now;
   logic                  side_now;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_comb begin
      count_in      = count_ff;
      left_time_in  = left_time_ff;
      right_time_in = right_time_ff;
      cleared       = 1'b0;
      // Left side first: a right edge sees the count as the left edge leaves it.
      if (echo_left != last_left_ff) begin
         if (echo_left) begin
            count_in = '0;
            cleared  = 1'b1;
         end else begin
            left_time_in = count_in;
         end
      end
      if (echo_right != last_right_ff) begin
         if (echo_right) begin
            count_in = '0;
            cleared  = 1'b1;
         end else begin
            right_time_in = count_in;
         end
      end
      if (!cleared) begin
         if (count_in >= cfg.counter_modulo) begin
            count_in = '0;
         end else begin
            count_in = count_in + 1'b1;
         end
      end
      last_left_in  = echo_left;
      last_right_in = echo_right;

      pulse_now     = pulse_ff;
      side_now      = side_right_ff;
      right_next_in = right_next_ff;
      if (start_trigger) begin
         pulse_now     = cfg.trigger_ticks;
         side_now      = right_next_ff;
         right_next_in = !right_next_ff;
      end
      side_right_in = side_now;
      pulse_in      = (pulse_now != '0) ? pulse_now - 1'b1 : pulse_now;

      word_in.trigger_left  = (pulse_now != '0) && !side_now;
      word_in.trigger_right = (pulse_now != '0) && side_now;
      word_in.left_time     = left_time_in;
      word_in.right_time    = right_time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_left_ff  <= 1'b0;
         last_right_ff <= 1'b0;
         count_ff      <= '0;
         left_time_ff  <= '0;
         right_time_ff <= '0;
         right_next_ff <= 1'b0;
         pulse_ff      <= '0;
         side_right_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            last_left_ff  <= last_left_in;
            last_right_ff <= last_right_in;
            count_ff      <= count_in;
            left_time_ff  <= left_time_in;
            right_time_ff <= right_time_in;
            right_next_ff <= right_next_in;
            pulse_ff      <= pulse_in;
            side_right_ff <= side_right_in;
         end
         if (in_ready) begin
            valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

endmodule

[hw/rtl/dsr_scale.sv]
// Two-stage echo time to millimetre conversion: scale multiply, then divide by 1000.
module dsr_scale
   import dsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [ScaleWidth-1:0] distance_scale,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tick_word_type         in_word,
   dsr_rsp_if.source             rsp
);

   logic                   prod_valid_ff;
   logic                   prod_ready;
   logic                   prod_trig_left_ff;
   logic                   prod_trig_right_ff;
   logic [ProdWidth-1:0]   prod_left_ff, prod_left_in;
   logic [ProdWidth-1:0]   prod_right_ff, prod_right_in;
   logic                   out_valid_ff;
   logic                   out_ready;
   logic                   out_trig_left_ff;
   logic                   out_trig_right_ff;
   logic [MmWidth-1:0]     left_mm_ff, left_mm_in;
   logic [MmWidth-1:0]     right_mm_ff, right_mm_in;
   logic [RecipProdWidth-1:0] recip_left;
   logic [RecipProdWidth-1:0] recip_right;
   logic [QuotWidth-1:0]   quot_left;
   logic [QuotWidth-1:0]   quot_right;

   assign out_ready  = !out_valid_ff || rsp.ready;
   assign prod_ready = !prod_valid_ff || out_ready;
   assign in_ready   = prod_ready;

   assign prod_left_in  = ProdWidth'(in_word.left_time) * ProdWidth'(distance_scale);
   assign prod_right_in = ProdWidth'(in_word.right_time) * ProdWidth'(distance_scale);

   assign recip_left  = RecipProdWidth'(prod_left_ff) * RecipProdWidth'(RecipMult);
   assign recip_right = RecipProdWidth'(prod_right_ff) * RecipProdWidth'(RecipMult);
   assign quot_left   = recip_left[RecipShift +: QuotWidth];
   assign quot_right  = recip_right[RecipShift +: QuotWidth];

   // Saturate quotients that overflow the distance field.
   assign left_mm_in  = quot_left[QuotWidth-1]  ? MmMax : quot_left[MmWidth-1:0];
   assign right_mm_in = quot_right[QuotWidth-1] ? MmMax : quot_right[MmWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (out_ready) begin
            out_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && prod_ready) begin
         prod_left_ff       <= prod_left_in;
         prod_right_ff      <= prod_right_in;
         prod_trig_left_ff  <= in_word.trigger_left;
         prod_trig_right_ff <= in_word.trigger_right;
      end
      if (prod_valid_ff && out_ready) begin
         left_mm_ff        <= left_mm_in;
         right_mm_ff       <= right_mm_in;
         out_trig_left_ff  <= prod_trig_left_ff;
         out_trig_right_ff <= prod_trig_right_ff;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.trigger_left  = out_trig_left_ff;
   assign rsp.trigger_right = out_trig_right_ff;
   assign rsp.left_mm       = left_mm_ff;
   assign rsp.right_mm      = right_mm_ff;

endmodule

[hw/rtl/dual_sonar_echo_ranger.sv]
// Top level of the dual sonar echo ranger: configuration registers and the tick pipeline.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------------------
//   req_chan | in        | valid/ready         | echo_left, echo_right, start_trigger
//   rsp_chan | out       | valid/ready         | trigger_left, trigger_right, left_mm, right_mm
//   csr_*    | in        | csr_write_en, no wait | csr_index, csr_write_data
//
// One word is taken every cycle while the response side is not stalled; each word's result
// passes through the tick register, the scale multiplier register and the divide-by-1000
// reciprocal multiplier register before it leaves.
// Reset is synchronous and clears counter, echo times, trigger state and all valid flags.
// A stalled response holds each stage only while the stage after it is full.
module dual_sonar_echo_ranger
   import dsr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   dsr_req_if.sink                 req_chan,
   dsr_rsp_if.source               rsp_chan,
   input  logic                    csr_write_en,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_write_data
);

   cfg_type       cfg_ff;
   logic          tick_valid;
   logic          tick_ready;
   tick_word_type tick_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.counter_modulo <= ModuloReset;
         cfg_ff.trigger_ticks  <= TicksReset;
         cfg_ff.distance_scale <= ScaleReset;
      end else if (csr_write_en) begin
         case (reg_index_type'(csr_index))
            REG_COUNTER_MODULO: cfg_ff.counter_modulo <= csr_write_data[TimeWidth-1:0];
            REG_TRIGGER_TICKS:  cfg_ff.trigger_ticks  <= csr_write_data[TicksWidth-1:0];
            REG_DISTANCE_SCALE: cfg_ff.distance_scale <= csr_write_data[ScaleWidth-1:0];
            default: ;
         endcase
      end
   end

   dsr_tick u_tick (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (req_chan.valid),
      .in_ready      (req_chan.ready),
      .echo_left     (req_chan.echo_left),
      .echo_right    (req_chan.echo_right),
      .start_trigger (req_chan.start_trigger),
      .out_valid     (tick_valid),
      .out_ready     (tick_ready),
      .out_word      (tick_word)
   );

   dsr_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .distance_scale (cfg_ff.distance_scale),
      .in_valid       (tick_valid),
      .in_ready       (tick_ready),
      .in_word        (tick_word),
      .rsp            (rsp_chan)
   );

endmodule

[verif/tb_dual_sonar_echo_ranger.sv]
// Self-checking testbench for the dual sonar echo ranger: ticks in, trigger and distance checks out.
module tb_dual_sonar_echo_ranger
   import dsr_pkg::*;
();

   localparam int unsigned CycleLimit  = 1000000;
   localparam int unsigned DrainCycles = 12;
   localparam int unsigned PhaseTicks  = 325;
   localparam longint unsigned MmDivisor = 1000;

   typedef struct packed {
      logic               trigger_left;
      logic               trigger_right;
      logic [MmWidth-1:0] left_mm;
      logic [MmWidth-1:0] right_mm;
   } ranging_result_type;

   logic clock = 1'b0;
   logic reset;
   logic                    csr_write_en;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [CsrDataWidth-1:0] csr_write_data;

   dsr_req_if req_if ();
   dsr_rsp_if rsp_if ();

   dual_sonar_echo_ranger u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #10 clock = ~clock;

   // ranging predictor state
   cfg_type             active_cfg = '{ModuloReset, TicksReset, ScaleReset};
   logic                prev_echo_left  = 1'b0;
   logic                prev_echo_right = 1'b0;
   logic [TimeWidth-1:0]  tick_count      = '0;
   logic [TimeWidth-1:0]  left_echo_time  = '0;
   logic [TimeWidth-1:0]  right_echo_time = '0;
   logic                fire_right_next = 1'b0;
   logic [TicksWidth-1:0] pulse_remaining = '0;
   logic                pulse_on_right  = 1'b0;

   ranging_result_type expected_ranges[$];

   int unsigned mismatches      = 0;
   int unsigned ticks_sent      = 0;
   int unsigned results_checked = 0;
   int unsigned config_phases   = 0;
   int unsigned hold_off_cycles = 0;
   bit          req_idle  = 1'b1;
   bit          rsp_idle  = 1'b1;
   bit          offering  = 1'b0;

   function automatic logic [MmWidth-1:0] echo_to_mm(logic [TimeWidth-1:0] echo_time);
      longint unsigned mm;
      mm = 64'(echo_time);
      mm = (mm * active_cfg.distance_scale) / MmDivisor;
      return (mm > MmMax) ? MmMax : mm[MmWidth-1:0];
   endfunction

   function automatic void predict_tick(logic el, logic er, logic st);
      ranging_result_type r;
      logic            counter_cleared;
      counter_cleared = 1'b0;
      // left edge first, so a right fall in the same tick sees the cleared counter
      if (el != prev_echo_left) begin
         if (el) begin
            tick_count = '0;
            counter_cleared = 1'b1;
         end else begin
            left_echo_time = tick_count;
         end
      end
      if (er != prev_echo_right) begin
         if (er) begin
            tick_count = '0;
            counter_cleared = 1'b1;
         end else begin
            right_echo_time = tick_count;
         end
      end
      prev_echo_left  = el;
      prev_echo_right = er;
      if (!counter_cleared) begin
         tick_count = (tick_count >= active_cfg.counter_modulo) ? '0 : tick_count + 1'b1;
      end
      if (st) begin
         pulse_remaining = active_cfg.trigger_ticks;
         pulse_on_right  = fire_right_next;
         fire_right_next = ~fire_right_next;
      end
      r.trigger_left  = (pulse_remaining != 0) && !pulse_on_right;
      r.trigger_right = (pulse_remaining != 0) && pulse_on_right;
      if (pulse_remaining != 0) pulse_remaining--;
      r.left_mm  = echo_to_mm(left_echo_time);
      r.right_mm = echo_to_mm(right_echo_time);
      expected_ranges.push_back(r);
   endfunction

   function automatic void compare_field(string field, logic [MmWidth-1:0] want,
                                         logic [MmWidth-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   task automatic check_result();
      ranging_result_type want;
      if (expected_ranges.size() == 0) begin
         $display("%0t: unexpected word, expected none, actual tl=%0b tr=%0b l=%0d r=%0d",
                  $time, rsp_if.trigger_left, rsp_if.trigger_right,
                  rsp_if.left_mm, rsp_if.right_mm);
         mismatches++;
         return;
      end
      want = expected_ranges.pop_front();
      results_checked++;
      compare_field("trigger_left", want.trigger_left, rsp_if.trigger_left);
      compare_field("trigger_right", want.trigger_right, rsp_if.trigger_right);
      compare_field("left_mm", want.left_mm, rsp_if.left_mm);
      compare_field("right_mm", want.right_mm, rsp_if.right_mm);
   endtask

   // Offer one tick and hold it until taken.
   task automatic send_tick(input logic el, input logic er, input logic st);
      int unsigned gap;
      gap = req_idle ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         if (offering) req_if.valid <= 1'b0;
         offering = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.echo_left     <= el;
      req_if.echo_right    <= er;
      req_if.start_trigger <= st;
      offering = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      predict_tick(el, er, st);
      ticks_sent++;
   endtask

   task automatic drain_results();
      if (offering) req_if.valid <= 1'b0;
      offering = 1'b0;
      while (expected_ranges.size() != 0) @(posedge clock);
   endtask

   // Leaves the write enable high; the caller drops it.
   task automatic write_register(input reg_index_type reg_idx,
                                 input logic [CsrDataWidth-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= reg_idx;
      csr_write_data <= data;
      @(posedge clock);
      case (reg_idx)
         REG_COUNTER_MODULO: active_cfg.counter_modulo = data[TimeWidth-1:0];
         REG_TRIGGER_TICKS:  active_cfg.trigger_ticks  = data[TicksWidth-1:0];
         REG_DISTANCE_SCALE: active_cfg.distance_scale = data[ScaleWidth-1:0];
         default: ;
      endcase
   endtask

   // Upper data bits beyond each field are filled with noise and must be dropped.
   task automatic set_config(input logic [TimeWidth-1:0] modulo,
                             input logic [TicksWidth-1:0] ticks,
                             input logic [ScaleWidth-1:0] scale);
      logic [CsrDataWidth-1:0] noise;
      noise = CsrDataWidth'($urandom);
      drain_results();
      write_register(REG_COUNTER_MODULO, modulo);
      write_register(REG_TRIGGER_TICKS, {noise[15:8], ticks});
      write_register(REG_DISTANCE_SCALE, {noise[15:10], scale});
      if ($urandom_range(0, 1)) write_register(REG_UNUSED, noise);
      csr_write_en <= 1'b0;
      config_phases++;
   endtask

   task automatic test_trigger_pulses();
      set_config(ModuloReset, 8'd3, ScaleReset);
      send_tick(1'b0, 1'b0, 1'b1);
      repeat (3) send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b1);
      // restart mid-pulse: the old side drops and the other fires
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b0);
      set_config(ModuloReset, 8'd0, ScaleReset);
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b1);
   endtask

   task automatic test_echo_edges();
      set_config(ModuloReset, TicksReset, 10'd1000);
      repeat (3) send_tick(1'b0, 1'b1, 1'b0);
      // left rise and right fall together: right latches the cleared counter
      repeat (3) send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);
      repeat (2) send_tick(1'b1, 1'b1, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_modulo_cases();
      set_config('0, TicksReset, 10'd1000);
      repeat (3) send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);
      set_config(16'hFFFF, TicksReset, 10'd1000);
      repeat (8) send_tick(1'b1, 1'b0, 1'b0);
      // lower the wrap point below the running count
      set_config(16'd3, TicksReset, 10'd1000);
      repeat (2) send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);
   endtask

   // Long echoes on both sides at the largest scale, back to back.
   task automatic test_wide_scale();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      set_config(16'hFFFF, TicksReset, 10'd1023);
      repeat (100) send_tick(1'b1, 1'b1, 1'b0);
      repeat (30) send_tick(1'b0, 1'b1, 1'b0);
      repeat (4) send_tick(1'b0, 1'b0, 1'b0);
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   task automatic test_backpressure();
      req_idle = 1'b0;
      hold_off_cycles = 150;
      for (int i = 0; i < 60; i++) begin
         send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), (i % 7) == 0);
      end
      req_idle = 1'b1;
   endtask

   task automatic test_random_ticks();
      logic        el;
      logic        er;
      logic        st;
      int unsigned flip_odds;
      el = 1'b0;
      er = 1'b0;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_config(ModuloReset, TicksReset, ScaleReset);
            1: set_config(16'd1, 8'd1, 10'd1);
            2: set_config(16'hFFFF, 8'hFF, 10'd1000);
            3: set_config(TimeWidth'($urandom_range(2, 300)),
                          TicksWidth'($urandom_range(1, 20)),
                          ScaleWidth'($urandom_range(1, 1023)));
            default: set_config('0, '0, 10'd1023);
         endcase
         flip_odds = $urandom_range(3, 60);
         for (int i = 0; i < PhaseTicks; i++) begin
            if (i % 40 == 0) begin
               req_idle = $urandom_range(0, 2) != 0;
               rsp_idle = $urandom_range(0, 2) != 0;
            end
            if ($urandom_range(0, 9) == 0) begin
               el = 1'($urandom_range(0, 1));
               er = 1'($urandom_range(0, 1));
               st = 1'($urandom_range(0, 1));
            end else begin
               if ($urandom_range(0, flip_odds) == 0) el = ~el;
               if ($urandom_range(0, flip_odds) == 0) er = ~er;
               st = $urandom_range(0, 11) == 0;
            end
            send_tick(el, er, st);
         end
      end
   endtask

   initial begin : result_checker
      int unsigned stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = rsp_idle ? $urandom_range(0, 16) : 0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         check_result();
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: run stopped after %0d cycles", $time, cycles);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.echo_left     <= 1'b0;
      req_if.echo_right    <= 1'b0;
      req_if.start_trigger <= 1'b0;
      csr_write_en         <= 1'b0;
      csr_index            <= REG_COUNTER_MODULO;
      csr_write_data       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_trigger_pulses();
      test_echo_edges();
      test_modulo_cases();
      test_wide_scale();
      test_backpressure();
      test_random_ticks();

      drain_results();
      repeat (DrainCycles) @(posedge clock);
      if (expected_ranges.size() != 0) mismatches++;

      $display("covered %0d ticks and %0d checked words over %0d register settings",
               ticks_sent, results_checked, config_phases);
      $display("incl. trigger alternation, echo edges, counter wrap, wide scale, stalls");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
